FILE: rtl/core/gpg_pkg.sv
// ----------------------------------------------------------------------------
// gpg_pkg
// Types, codes and constant tables of the gradient position generator.
// ----------------------------------------------------------------------------
package gpg_pkg;

    localparam int COORD_W     = 16;
    localparam int PIX_W       = 15;
    localparam int DIFF_W      = 18;
    localparam int PROD_W      = 36;
    localparam int SUM_W       = 37;
    localparam int MAG_W       = 33;
    localparam int DW          = 33;
    localparam int RT_W        = 64;
    localparam int ROOT_STEPS  = 32;
    localparam int ROOT_SCALE  = 30;
    localparam int CW          = 44;
    localparam int ANG_W       = 32;
    localparam int ANGLE_SCALE = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int SHAPE_W     = 3;
    localparam int REPEAT_W    = 2;
    localparam int ATAN_ENTRIES = 24;

    localparam logic [SHAPE_W-1:0] SHAPE_LINEAR      = 3'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_BILINEAR    = 3'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_RADIAL      = 3'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_SQUARE      = 3'd3;
    localparam logic [SHAPE_W-1:0] SHAPE_CONICAL     = 3'd4;
    localparam logic [SHAPE_W-1:0] SHAPE_CONICAL_SYM = 3'd5;

    localparam logic [REPEAT_W-1:0] REPEAT_CLAMP     = 2'd0;
    localparam logic [REPEAT_W-1:0] REPEAT_FORWARD   = 2'd1;
    localparam logic [REPEAT_W-1:0] REPEAT_ALTERNATE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_START_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_MODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MODE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE     = 3'd6;

    localparam logic [ANG_W-1:0] ANG_QUARTER    = 32'h4000_0000;
    localparam logic [ANG_W-1:0] ANG_HALF       = 32'h8000_0000;
    localparam logic [ANG_W-1:0] ANG_3QUARTER   = 32'hC000_0000;

    // atan(2^-i) in 2^-32 turns
    localparam logic [ANG_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680348,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic [RT_W-1:0] v;
        logic [RT_W-1:0] r;
    } root_lane_t;

    typedef struct packed {
        logic [MAG_W-1:0] m;
        logic [DW-1:0]    len2;
        logic             neg;
        logic             zero;
    } root_side_t;

    typedef struct packed {
        logic neg;
        logic zero;
    } div_side_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [ANG_W-1:0]     z;
        logic                 fix;
    } angle_lane_t;

endpackage

FILE: rtl/core/gpg_angle_cell.sv
// ----------------------------------------------------------------------------
// gpg_angle_cell
// One CORDIC vectoring step for the pixel and gradient vector angles.
// ----------------------------------------------------------------------------
module gpg_angle_cell #(
    parameter int I = 0
) (
    input  logic                 clk,
    input  gpg_pkg::angle_lane_t pix_in,
    input  gpg_pkg::angle_lane_t vec_in,
    output gpg_pkg::angle_lane_t pix_out,
    output gpg_pkg::angle_lane_t vec_out
);

    gpg_pkg::angle_lane_t pix_reg;
    gpg_pkg::angle_lane_t vec_reg;
    gpg_pkg::angle_lane_t pix_next;
    gpg_pkg::angle_lane_t vec_next;

    function automatic gpg_pkg::angle_lane_t rotate(gpg_pkg::angle_lane_t l);
        gpg_pkg::angle_lane_t res;
        logic signed [gpg_pkg::CW-1:0] xs;
        logic signed [gpg_pkg::CW-1:0] ys;
        res = l;
        xs  = l.x >>> I;
        ys  = l.y >>> I;
        if (!l.fix)
        begin
            if (l.y > 0)
            begin
                res.x = l.x + ys;
                res.y = l.y - xs;
                res.z = l.z + gpg_pkg::ATAN_TURNS[I];
            end
            else
            begin
                res.x = l.x - ys;
                res.y = l.y + xs;
                res.z = l.z - gpg_pkg::ATAN_TURNS[I];
            end
        end
        return res;
    endfunction

    always_comb
    begin
        pix_next = rotate(pix_in);
        vec_next = rotate(vec_in);
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
        vec_reg <= vec_next;
    end

    assign pix_out = pix_reg;
    assign vec_out = vec_reg;

endmodule

FILE: rtl/core/gpg_root_cell.sv
// ----------------------------------------------------------------------------
// gpg_root_cell
// One digit step of the integer square roots of both distances.
// ----------------------------------------------------------------------------
module gpg_root_cell #(
    parameter int K = 0
) (
    input  logic                clk,
    input  gpg_pkg::root_lane_t p_in,
    input  gpg_pkg::root_lane_t q_in,
    input  gpg_pkg::root_side_t side_in,
    output gpg_pkg::root_lane_t p_out,
    output gpg_pkg::root_lane_t q_out,
    output gpg_pkg::root_side_t side_out
);

    localparam logic [gpg_pkg::RT_W-1:0] BIT = gpg_pkg::RT_W'(1) << (62 - 2 * K);

    gpg_pkg::root_lane_t p_reg;
    gpg_pkg::root_lane_t q_reg;
    gpg_pkg::root_side_t side_reg;
    gpg_pkg::root_lane_t p_next;
    gpg_pkg::root_lane_t q_next;

    function automatic gpg_pkg::root_lane_t step(gpg_pkg::root_lane_t l);
        gpg_pkg::root_lane_t res;
        logic [gpg_pkg::RT_W-1:0] trial;
        trial = l.r + BIT;
        if (l.v >= trial)
        begin
            res.v = l.v - trial;
            res.r = (l.r >> 1) + BIT;
        end
        else
        begin
            res.v = l.v;
            res.r = l.r >> 1;
        end
        return res;
    endfunction

    always_comb
    begin
        p_next = step(p_in);
        q_next = step(q_in);
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        q_reg    <= q_next;
        side_reg <= side_in;
    end

    assign p_out    = p_reg;
    assign q_out    = q_reg;
    assign side_out = side_reg;

endmodule

FILE: rtl/core/gpg_div_cell.sv
// ----------------------------------------------------------------------------
// gpg_div_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module gpg_div_cell #(
    parameter int QW = 34
) (
    input  logic                        clk,
    input  logic [gpg_pkg::DW+QW-1:0]   acc_in,
    input  logic [gpg_pkg::DW-1:0]      den_in,
    input  gpg_pkg::div_side_t          side_in,
    output logic [gpg_pkg::DW+QW-1:0]   acc_out,
    output logic [gpg_pkg::DW-1:0]      den_out,
    output gpg_pkg::div_side_t          side_out
);

    localparam int DW = gpg_pkg::DW;
    localparam int AW = DW + QW;

    logic [AW-1:0]      acc_reg;
    logic [AW-1:0]      acc_next;
    logic [DW-1:0]      den_reg;
    gpg_pkg::div_side_t side_reg;
    logic [DW:0]        part;
    logic [DW:0]        diff;

    always_comb
    begin
        part = acc_in[AW-1:QW-1];
        diff = part - {1'b0, den_in};
        if (part >= {1'b0, den_in})
        begin
            acc_next = {diff[DW-1:0], acc_in[QW-2:0], 1'b1};
        end
        else
        begin
            acc_next = {part[DW-1:0], acc_in[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        den_reg  <= den_in;
        side_reg <= side_in;
    end

    assign acc_out  = acc_reg;
    assign den_out  = den_reg;
    assign side_out = side_reg;

endmodule

FILE: rtl/core/gradient_position_generator_unit.sv
// ----------------------------------------------------------------------------
// gradient_position_generator_unit
// Gradient position t of a pixel: linear, bilinear, radial, square and
// conical shapes, repeat folding and reverse.
// ----------------------------------------------------------------------------
// Pipeline: done rises for an accepted item after 72 register stages (by
//   default), the first loaded at the accepting edge - four set-up
//   stages, a 32-cell square root chain, a divider set-up stage,
//   T_FRAC_BITS+18 divider cells and the output stage. The angle chain runs
//   alongside.
// Throughput: one item per cycle; busy stays low, results cannot be held off.
// Reset clears the configuration registers and the valid chain.
// ----------------------------------------------------------------------------
module gradient_position_generator_unit #(
    parameter int T_FRAC_BITS      = 16,
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [gpg_pkg::PIX_W-1:0]         pixel_x,
    input  logic [gpg_pkg::PIX_W-1:0]         pixel_y,
    output logic                              done,
    output logic [T_FRAC_BITS:0]              t_value,
    input  logic                              cfg_we,
    input  logic [gpg_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [gpg_pkg::COORD_W-1:0]       cfg_wdata
);

    localparam int F    = T_FRAC_BITS;
    localparam int AI   = ANGLE_ITERATIONS;
    localparam int QW   = F + 18;
    localparam int DW   = gpg_pkg::DW;
    localparam int AW   = DW + QW;
    localparam int RS   = gpg_pkg::ROOT_STEPS;
    localparam int LAT  = 38 + QW;
    localparam int CDLY = 34 + QW - AI;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    localparam int DIFF_W = gpg_pkg::DIFF_W;
    localparam int PROD_W = gpg_pkg::PROD_W;
    localparam int SUM_W  = gpg_pkg::SUM_W;
    localparam int MAG_W  = gpg_pkg::MAG_W;

    // configuration
    logic signed [gpg_pkg::COORD_W-1:0] start_x_reg;
    logic signed [gpg_pkg::COORD_W-1:0] start_y_reg;
    logic signed [gpg_pkg::COORD_W-1:0] end_x_reg;
    logic signed [gpg_pkg::COORD_W-1:0] end_y_reg;
    logic [gpg_pkg::SHAPE_W-1:0]        shape_reg;
    logic [gpg_pkg::REPEAT_W-1:0]       repeat_reg;
    logic                               reverse_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
            shape_reg   <= gpg_pkg::SHAPE_LINEAR;
            repeat_reg  <= gpg_pkg::REPEAT_CLAMP;
            reverse_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                gpg_pkg::REG_START_X:     start_x_reg <= cfg_wdata;
                gpg_pkg::REG_START_Y:     start_y_reg <= cfg_wdata;
                gpg_pkg::REG_END_X:       end_x_reg   <= cfg_wdata;
                gpg_pkg::REG_END_Y:       end_y_reg   <= cfg_wdata;
                gpg_pkg::REG_SHAPE_MODE:  shape_reg   <= cfg_wdata[gpg_pkg::SHAPE_W-1:0];
                gpg_pkg::REG_REPEAT_MODE: repeat_reg  <= cfg_wdata[gpg_pkg::REPEAT_W-1:0];
                gpg_pkg::REG_REVERSE:     reverse_reg <= cfg_wdata[0];
                default:                  ;
            endcase
        end
    end

    logic is_conical;
    logic is_radial;
    logic is_abs;

    always_comb
    begin
        is_conical = (shape_reg == gpg_pkg::SHAPE_CONICAL)
                  || (shape_reg == gpg_pkg::SHAPE_CONICAL_SYM);
        is_radial  = shape_reg == gpg_pkg::SHAPE_RADIAL;
        is_abs     = (shape_reg == gpg_pkg::SHAPE_BILINEAR)
                  || (shape_reg == gpg_pkg::SHAPE_SQUARE);
    end

    // valid chain
    logic       accept;
    logic [LAT-1:0] vld_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], accept};
        end
    end

    // stage 1: differences
    logic signed [DIFF_W-1:0] px_reg, py_reg, dx_reg, dy_reg;
    logic signed [DIFF_W-1:0] px_next, py_next, dx_next, dy_next;

    always_comb
    begin
        px_next = signed'(DIFF_W'(pixel_x)) - DIFF_W'(start_x_reg);
        py_next = signed'(DIFF_W'(pixel_y)) - DIFF_W'(start_y_reg);
        dx_next = DIFF_W'(end_x_reg) - DIFF_W'(start_x_reg);
        dy_next = DIFF_W'(end_y_reg) - DIFF_W'(start_y_reg);
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
        py_reg <= py_next;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
    end

    // stage 2: products and angle set-up
    logic signed [PROD_W-1:0] pxdx_reg, pydy_reg, pxdy_reg, pydx_reg;
    logic signed [PROD_W-1:0] pxpx_reg, pypy_reg, dxdx_reg, dydy_reg;
    gpg_pkg::angle_lane_t     ang_p [AI+1];
    gpg_pkg::angle_lane_t     ang_v [AI+1];

    function automatic gpg_pkg::angle_lane_t angle_prep(logic signed [DIFF_W-1:0] x,
                                                        logic signed [DIFF_W-1:0] y);
        gpg_pkg::angle_lane_t res;
        logic signed [gpg_pkg::CW-1:0] xe;
        logic signed [gpg_pkg::CW-1:0] ye;
        xe      = gpg_pkg::CW'(x);
        ye      = gpg_pkg::CW'(y);
        res.fix = 1'b1;
        res.x   = '0;
        res.y   = '0;
        res.z   = '0;
        if (x == 0 && y == 0)
        begin
            res.z = '0;
        end
        else if (y == 0)
        begin
            res.z = (x > 0) ? '0 : gpg_pkg::ANG_HALF;
        end
        else if (x == 0)
        begin
            res.z = (y > 0) ? gpg_pkg::ANG_QUARTER : gpg_pkg::ANG_3QUARTER;
        end
        else
        begin
            res.fix = 1'b0;
            if (x < 0)
            begin
                res.x = (-xe) <<< gpg_pkg::ANGLE_SCALE;
                res.y = (-ye) <<< gpg_pkg::ANGLE_SCALE;
                res.z = gpg_pkg::ANG_HALF;
            end
            else
            begin
                res.x = xe <<< gpg_pkg::ANGLE_SCALE;
                res.y = ye <<< gpg_pkg::ANGLE_SCALE;
            end
        end
        return res;
    endfunction

    always_ff @(posedge clk)
    begin
        pxdx_reg <= px_reg * dx_reg;
        pydy_reg <= py_reg * dy_reg;
        pxdy_reg <= px_reg * dy_reg;
        pydx_reg <= py_reg * dx_reg;
        pxpx_reg <= px_reg * px_reg;
        pypy_reg <= py_reg * py_reg;
        dxdx_reg <= dx_reg * dx_reg;
        dydy_reg <= dy_reg * dy_reg;
        ang_p[0] <= angle_prep(px_reg, py_reg);
        ang_v[0] <= angle_prep(dx_reg, dy_reg);
    end

    // stage 3: sums
    logic signed [SUM_W-1:0] dot_reg, cross_reg;
    logic [MAG_W-1:0]        pp_reg, len2_reg;
    logic signed [SUM_W-1:0] dot_next, cross_next;
    logic [MAG_W-1:0]        pp_next, len2_next;

    always_comb
    begin
        dot_next   = SUM_W'(pxdx_reg) + SUM_W'(pydy_reg);
        cross_next = SUM_W'(pxdy_reg) - SUM_W'(pydx_reg);
        pp_next    = MAG_W'(pxpx_reg[31:0]) + MAG_W'(pypy_reg[31:0]);
        len2_next  = MAG_W'(dxdx_reg[31:0]) + MAG_W'(dydy_reg[31:0]);
    end

    always_ff @(posedge clk)
    begin
        dot_reg   <= dot_next;
        cross_reg <= cross_next;
        pp_reg    <= pp_next;
        len2_reg  <= len2_next;
    end

    // stage 4: operand selection, root chain set-up
    gpg_pkg::root_lane_t rt_p [RS+1];
    gpg_pkg::root_lane_t rt_q [RS+1];
    gpg_pkg::root_side_t rt_s [RS+1];
    gpg_pkg::root_side_t side_next;
    logic signed [SUM_W-1:0] dot_abs, cross_abs;

    always_comb
    begin
        dot_abs   = dot_reg[SUM_W-1] ? -dot_reg : dot_reg;
        cross_abs = cross_reg[SUM_W-1] ? -cross_reg : cross_reg;
        side_next.m = dot_abs[MAG_W-1:0];
        if (shape_reg == gpg_pkg::SHAPE_SQUARE && cross_abs > dot_abs)
        begin
            side_next.m = cross_abs[MAG_W-1:0];
        end
        side_next.len2 = len2_reg;
        side_next.neg  = dot_reg[SUM_W-1] && !is_abs && !is_radial;
        side_next.zero = len2_reg == '0;
    end

    always_ff @(posedge clk)
    begin
        rt_p[0].v <= gpg_pkg::RT_W'({pp_reg, {gpg_pkg::ROOT_SCALE{1'b0}}});
        rt_p[0].r <= '0;
        rt_q[0].v <= gpg_pkg::RT_W'({len2_reg, {gpg_pkg::ROOT_SCALE{1'b0}}});
        rt_q[0].r <= '0;
        rt_s[0]   <= side_next;
    end

    for (genvar k = 0; k < RS; k++)
    begin : g_root
        gpg_root_cell #(.K(k)) u_cell (
            .clk      (clk),
            .p_in     (rt_p[k]),
            .q_in     (rt_q[k]),
            .side_in  (rt_s[k]),
            .p_out    (rt_p[k+1]),
            .q_out    (rt_q[k+1]),
            .side_out (rt_s[k+1])
        );
    end

    // divider set-up
    logic [AW-1:0]      dv_acc  [QW+1];
    logic [DW-1:0]      dv_den  [QW+1];
    gpg_pkg::div_side_t dv_side [QW+1];
    logic [MAG_W-1:0]   num_sel;
    logic [DW-1:0]      den_sel;

    always_comb
    begin
        num_sel = is_radial ? rt_p[RS].r[MAG_W-1:0] : rt_s[RS].m;
        den_sel = is_radial ? rt_q[RS].r[DW-1:0] : rt_s[RS].len2;
    end

    always_ff @(posedge clk)
    begin
        dv_acc[0]       <= AW'(num_sel) << F;
        dv_den[0]       <= den_sel;
        dv_side[0].neg  <= rt_s[RS].neg;
        dv_side[0].zero <= rt_s[RS].zero;
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        gpg_div_cell #(.QW(QW)) u_cell (
            .clk      (clk),
            .acc_in   (dv_acc[k]),
            .den_in   (dv_den[k]),
            .side_in  (dv_side[k]),
            .acc_out  (dv_acc[k+1]),
            .den_out  (dv_den[k+1]),
            .side_out (dv_side[k+1])
        );
    end

    // angle chain
    for (genvar i = 0; i < AI; i++)
    begin : g_angle
        gpg_angle_cell #(.I(i)) u_cell (
            .clk     (clk),
            .pix_in  (ang_p[i]),
            .vec_in  (ang_v[i]),
            .pix_out (ang_p[i+1]),
            .vec_out (ang_v[i+1])
        );
    end

    logic [gpg_pkg::ANG_W-1:0] ang_diff;
    logic [gpg_pkg::ANG_W:0]   ang_fold;
    logic [F:0]                cone_next;
    logic [F:0]                cone_reg;
    logic [F:0]                cone_dly_reg [CDLY];

    always_comb
    begin
        ang_diff = ang_p[AI].z - ang_v[AI].z;
        ang_fold = ang_diff[gpg_pkg::ANG_W-1]
                 ? {1'b1, {gpg_pkg::ANG_W{1'b0}}} - {1'b0, ang_diff}
                 : {1'b0, ang_diff};
        if (shape_reg == gpg_pkg::SHAPE_CONICAL_SYM)
        begin
            cone_next = (F+1)'(ang_fold >> (31 - F));
        end
        else
        begin
            cone_next = (F+1)'(ang_diff >> (32 - F));
        end
    end

    always_ff @(posedge clk)
    begin
        cone_reg        <= cone_next;
        cone_dly_reg[0] <= cone_reg;
        for (int n = 1; n < CDLY; n++)
        begin
            cone_dly_reg[n] <= cone_dly_reg[n-1];
        end
    end

    // output stage: repeat folding and reverse
    logic [QW-1:0] quo;
    logic [DW-1:0] rem;
    logic [QW:0]   mag;
    logic          sgn;
    logic [F:0]    frac;
    logic [F:0]    fold;
    logic [F:0]    t_next;
    logic [F:0]    t_reg;

    always_comb
    begin
        quo = dv_acc[QW][QW-1:0];
        rem = dv_acc[QW][AW-1:QW];
        if (is_conical)
        begin
            mag = (QW+1)'(cone_dly_reg[CDLY-1]);
            sgn = 1'b0;
        end
        else if (dv_side[QW].zero)
        begin
            mag = '0;
            sgn = 1'b0;
        end
        else if (dv_side[QW].neg)
        begin
            mag = {1'b0, quo} + (QW+1)'(rem != '0);
            sgn = 1'b1;
        end
        else
        begin
            mag = {1'b0, quo};
            sgn = 1'b0;
        end
        frac = {1'b0, mag[F-1:0]};
        case (repeat_reg)
            gpg_pkg::REPEAT_FORWARD:
            begin
                fold = (!sgn && mag != '0) ? frac : ONE - frac;
            end
            gpg_pkg::REPEAT_ALTERNATE:
            begin
                fold = mag[F] ? ONE - frac : frac;
            end
            default:
            begin
                if (sgn || mag == '0)
                begin
                    fold = '0;
                end
                else if (mag[QW:F] != '0)
                begin
                    fold = ONE;
                end
                else
                begin
                    fold = frac;
                end
            end
        endcase
        t_next = reverse_reg ? ONE - fold : fold;
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
    end

    assign t_value = t_reg;
    assign done    = vld_reg[LAT-1];

    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> t_value <= ONE)
        else $error("t_value above one");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("done without matching accepted item");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[LAT-2] && !dv_side[QW].zero) |-> rem < dv_den[QW])
        else $error("divider remainder not below divisor");

endmodule
